@@ rtl/string_bucket_hash_macros.svh @@
// assertion macros for the bucket hash rtl
`ifndef STRING_BUCKET_HASH_MACROS_SVH
`define STRING_BUCKET_HASH_MACROS_SVH

// same-cycle implication, off during reset
`define SBH_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SBH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sbh_pkg.sv @@
// types and constants for the string bucket hash
package sbh_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned MASK_W    = 30;
  localparam int unsigned BUCKET_W  = 20;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned CNT_W     = $clog2(MASK_W);

  localparam logic [ACC_W-1:0]    HASH_MULT       = ACC_W'(613);
  localparam logic [BUCKET_W-1:0] MAX_NAME_LENGTH = BUCKET_W'(65535);
  localparam logic [BUCKET_W-1:0] BUCKET_RESET    = BUCKET_W'(1024);
  localparam logic [CNT_W-1:0]    DIV_LAST_STEP   = CNT_W'(MASK_W - 1);

  // register index as decoded from paddr bit 2
  localparam logic REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } sbh_state_t;

endpackage

@@ rtl/sbh_in_if.sv @@
// request channel carrying one name character
interface sbh_in_if import sbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic [LEN_W-1:0]  name_length;
  logic              first_of_name;
  logic              last_of_name;
  logic              empty_name;

  modport source (
    output valid, name_byte, name_length, first_of_name, last_of_name, empty_name,
    input  ready
  );
  modport sink (
    input  valid, name_byte, name_length, first_of_name, last_of_name, empty_name,
    output ready
  );
endinterface

@@ rtl/sbh_out_if.sv @@
// result channel carrying one bucket index
interface sbh_out_if import sbh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket_index;

  modport source (output valid, bucket_index, input ready);
  modport sink   (input valid, bucket_index, output ready);
endinterface

@@ rtl/string_bucket_hash.sv @@
// polynomial name hash with iterative modulo into a bucket index
// a character without the last mark is taken while idle and folded into the accumulator
// a last character is hashed as it is taken, then runs through the restoring
// modulo unit (one remainder bit per cycle), then the result is held until taken
// empty name or zero bucket count: result shows the cycle after the request
// synchronous reset clears the accumulator, sets bucket_count to 1024, goes idle
`include "string_bucket_hash_macros.svh"

module string_bucket_hash import sbh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  sbh_in_if.sink            name_chan,
  sbh_out_if.source         bucket_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  sbh_state_t          state, state_next;
  logic [ACC_W-1:0]    acc;
  logic [BUCKET_W-1:0] bucket_count;
  logic [BUCKET_W-1:0] dvsr;
  logic [BUCKET_W-1:0] rem;
  logic [MASK_W-1:0]   quo;
  logic [CNT_W-1:0]    step;
  logic [BUCKET_W-1:0] out_idx;

  logic                in_acc;
  logic                cfg_wr;
  logic [BUCKET_W-1:0] len_sat;
  logic [ACC_W-1:0]    seed;
  logic [ACC_W-1:0]    prod;
  logic [ACC_W-1:0]    acc_new;
  logic [BUCKET_W:0]   cand;
  logic                fits;
  logic [BUCKET_W-1:0] rem_next;

  assign in_acc = name_chan.valid && name_chan.ready;
  assign cfg_wr = psel && penable && pwrite && pready;

  // multiply-add for one character
  always_comb begin
    len_sat = BUCKET_W'(name_chan.name_length);
    if (len_sat > MAX_NAME_LENGTH) begin
      len_sat = MAX_NAME_LENGTH;
    end
    seed    = name_chan.first_of_name ? ACC_W'(len_sat) : acc;
    prod    = seed * HASH_MULT;
    acc_new = prod + {{(ACC_W-BYTE_W){name_chan.name_byte[BYTE_W-1]}}, name_chan.name_byte};
  end

  // one restoring step of the modulo unit
  always_comb begin
    cand     = {rem, quo[MASK_W-1]};
    fits     = cand >= {1'b0, dvsr};
    rem_next = fits ? BUCKET_W'(cand - {1'b0, dvsr}) : cand[BUCKET_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (name_chan.empty_name ||
                       (name_chan.last_of_name && bucket_count == '0))) begin
          state_next = ST_OUT;
        end else if (in_acc && name_chan.last_of_name) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step == DIV_LAST_STEP) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (bucket_chan.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    name_chan.ready          = (state == ST_IDLE);
    bucket_chan.valid        = (state == ST_OUT);
    bucket_chan.bucket_index = out_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (in_acc) begin
      acc <= name_chan.empty_name ? '0 : acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_RESET;
    end else if (cfg_wr && paddr[2] == REG_BUCKET_COUNT) begin
      bucket_count <= pwdata[BUCKET_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvsr <= BUCKET_RESET;
    end else if (state == ST_IDLE) begin
      dvsr <= bucket_count;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      rem     <= '0;
      quo     <= acc_new[MASK_W-1:0];
      step    <= '0;
      out_idx <= '0;
    end else if (state == ST_DIV) begin
      rem  <= rem_next;
      quo  <= {quo[MASK_W-2:0], 1'b0};
      step <= step + CNT_W'(1);
      if (step == DIV_LAST_STEP) begin
        out_idx <= rem_next;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BUCKET_COUNT) ? APB_DW'(bucket_count) : '0;

  `SBH_ASSERT_NOW(a_no_overlap, clk, rst, name_chan.ready, !bucket_chan.valid,
    "request taken while a result is pending")
  `SBH_ASSERT_NOW(a_rem_bound, clk, rst, state == ST_DIV, rem < dvsr,
    "partial remainder not below divisor")
  `SBH_ASSERT_NEXT(a_empty_zero, clk, rst, in_acc && name_chan.empty_name,
    bucket_chan.valid && bucket_chan.bucket_index == '0 && acc == '0,
    "empty name did not give bucket zero")
  `SBH_ASSERT_NEXT(a_last_starts, clk, rst,
    in_acc && !name_chan.empty_name && name_chan.last_of_name,
    state == ST_DIV || bucket_chan.valid,
    "last character did not start the reduction")

endmodule
